// File: hdl/b2da_pkg.sv
// shared types, constants and helpers for the binary to decimal ascii unit
package b2da_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF = 20;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CHAR_W         = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_DONE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } back_state_e;

  // double-dabble digit correction before each shift
  function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = d;
    if (d >= DIGIT_W'(5)) begin
      r = d + DIGIT_W'(3);
    end
    return r;
  endfunction

endpackage

// File: hdl/b2da_front.sv
// front end: accepts a value and converts it to bcd with a shift-add-3 loop
module b2da_front #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [63:0]                           value_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output logic [MAX_DIGITS*b2da_pkg::DIGIT_W:0] push_data_o
);
  import b2da_pkg::*;

  localparam int unsigned BCD_W  = MAX_DIGITS * DIGIT_W;
  localparam int unsigned BITS_W = $clog2(VALUE_BITS);

  front_state_e          state_q, state_d;
  logic [VALUE_BITS-1:0] shift_q;
  logic [BCD_W-1:0]      bcd_q;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  ovf_q;
  logic [BITS_W-1:0]     bit_cnt_q;
  logic                  take;
  logic                  push;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_CONV;
      end
      F_CONV: begin
        if (bit_cnt_q == '0) state_d = F_DONE;
      end
      F_DONE: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      F_IDLE:  in_ready_o   = 1'b1;
      F_DONE:  push_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign take        = in_valid_i && in_ready_o;
  assign push        = push_valid_o && push_ready_i;
  assign push_data_o = {ovf_q, bcd_q};

  always_comb begin
    for (int unsigned k = 0; k < MAX_DIGITS; k++) begin
      bcd_adj[k*DIGIT_W +: DIGIT_W] = add3(bcd_q[k*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      shift_q   <= value_i[VALUE_BITS-1:0];
      bcd_q     <= '0;
      ovf_q     <= 1'b0;
      bit_cnt_q <= BITS_W'(VALUE_BITS - 1);
    end else if (state_q == F_CONV) begin
      // a carry out of the top digit means the digit window overflowed
      bcd_q     <= {bcd_adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
      ovf_q     <= ovf_q | bcd_adj[BCD_W-1];
      shift_q   <= {shift_q[VALUE_BITS-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q - BITS_W'(1);
    end else if (push) begin
      ovf_q <= 1'b0;
    end
  end

endmodule

// File: hdl/b2da_queue.sv
// short queue of converted bcd words between front and back
module b2da_queue #(
  parameter int unsigned WIDTH = b2da_pkg::MAX_DIGITS_DEF * b2da_pkg::DIGIT_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import b2da_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr_en, rd_en;

  assign wr_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (rd_en) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/b2da_back.sv
// back end: skips leading zeros and sends one ascii digit per transfer
module b2da_back #(
  parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  pop_valid_i,
  output logic                                  pop_ready_o,
  input  logic [MAX_DIGITS*b2da_pkg::DIGIT_W:0] pop_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]           char_code_o,
  output logic                                  last_of_run_o
);
  import b2da_pkg::*;

  localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;
  localparam int unsigned REM_W = $clog2(MAX_DIGITS + 1);

  back_state_e        state_q, state_d;
  logic [BCD_W-1:0]   digits_q;
  logic [DIGIT_W-1:0] top;
  logic               ovf_q;
  logic [REM_W-1:0]   rem_q;
  logic               out_vld_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic               pop;
  logic               skip;
  logic               emit;

  assign top = digits_q[BCD_W-1 -: DIGIT_W];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) state_d = B_SCAN;
      end
      B_SCAN: begin
        if (!skip) state_d = B_EMIT;
      end
      B_EMIT: begin
        if (emit && rem_q == REM_W'(1)) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs and the skip and emit controls
  always_comb begin
    pop_ready_o = 1'b0;
    skip        = 1'b0;
    emit        = 1'b0;
    case (state_q)
      B_IDLE: pop_ready_o = 1'b1;
      B_SCAN: skip = !ovf_q && (rem_q > REM_W'(1)) && (top == '0);
      B_EMIT: emit = !out_vld_q || out_ready_i;
      default: ;
    endcase
  end

  assign pop = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      digits_q <= pop_data_i[BCD_W-1:0];
      ovf_q    <= pop_data_i[BCD_W];
      rem_q    <= REM_W'(MAX_DIGITS);
    end else if (skip || emit) begin
      digits_q <= {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_q    <= rem_q - REM_W'(1);
    end
    if (emit) begin
      char_q <= ASCII_ZERO + CHAR_W'(top);
      last_q <= rem_q == REM_W'(1);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign char_code_o   = char_q;
  assign last_of_run_o = last_q;

endmodule

// File: hdl/binary_to_decimal_ascii_unit.sv
// top level of the binary to decimal ascii unit
// Writes an unsigned value (low VALUE_BITS bits of value_i) in decimal as ASCII digits, most
// significant first, leading zeros suppressed, zero as a single '0'; last_of_run_o marks the
// final digit. A value with more than MAX_DIGITS digits keeps all its low MAX_DIGITS digits,
// zeros included. The front converter runs one shift-add-3 step per input bit and is ready
// again right after handing its result to a two-entry queue. The back end then loads the
// word, drops one suppressed leading zero per scan step, leaves the scan and sends one digit
// per transfer. The two ends overlap through the queue.
module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [63:0]                 value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0] char_code_o,
  output logic                        last_of_run_o
);
  import b2da_pkg::*;

  localparam int unsigned ENTRY_W = MAX_DIGITS * DIGIT_W + 1;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  b2da_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  b2da_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i (push_data),
    .rd_valid_o(pop_valid),
    .rd_ready_i(pop_ready),
    .rd_data_o (pop_data)
  );

  b2da_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_code_o  (char_code_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// File: hdl/b2da_checker.sv
// port-level checks for the binary to decimal ascii unit and their binding
module b2da_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [b2da_pkg::CHAR_W-1:0] char_code_o,
  input logic                        last_of_run_o
);
  import b2da_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(char_code_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // every character is a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_code_o >= ASCII_ZERO && char_code_o <= ASCII_NINE)
    else $error("character is not a decimal digit");

  // converter is busy right after taking a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while conversion runs");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .char_code_o  (char_code_o),
  .last_of_run_o(last_of_run_o)
);

// File: test/binary_to_decimal_ascii_unit_test.sv
// testbench for the binary to decimal ascii unit: table and random values, digit by digit
module binary_to_decimal_ascii_unit_test;
  import b2da_pkg::*;

  localparam int unsigned ValueBits    = VALUE_BITS_DEF;
  localparam int unsigned MaxDigits    = MAX_DIGITS_DEF;
  localparam int unsigned TableRows    = 20;
  localparam int unsigned RandomValues = 300;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 2 * (ValueBits + 2 + MaxDigits);
  localparam logic [63:0] ValueMask    =
    (ValueBits >= 64) ? '1 : ((64'd1 << ValueBits) - 64'd1);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_char_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [63:0]       value;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] char_code;
  logic              last_of_run;

  logic              steady;
  int unsigned       ready_hold = 0;
  int unsigned       cycles = 0;
  int unsigned       errors = 0;
  int unsigned       values_sent = 0;
  int unsigned       chars_seen = 0;
  int unsigned       runs_seen = 0;

  digit_char_t       digit_chars_q[$];

  // empty digit string: expectation comes from the decimal predictor
  logic [63:0] table_values [TableRows] = '{
    64'd0, 64'd1, 64'd9, 64'd10,
    64'hFFFF_FFFF_FFFF_FFFF, 64'd10000000000000000000, 64'd9999999999999999999,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF,
    64'd100, 64'd255, 64'd1000000, 64'd999999,
    64'd4294967295, 64'd4294967296, 64'd12345678901234567890, 64'hFFFF_FFFF_FFFF_FFFE
  };
  string table_digits [TableRows] = '{
    "0", "1", "9", "10",
    "18446744073709551615", "10000000000000000000", "9999999999999999999",
    "9223372036854775808", "9223372036854775807",
    "", "", "",
    "100", "", "", "",
    "4294967295", "", "12345678901234567890", ""
  };

  binary_to_decimal_ascii_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .char_code_o  (char_code),
    .last_of_run_o(last_of_run)
  );

  always #5 clk = ~clk;

  function automatic void expect_decimal(input logic [63:0] number);
    logic [DIGIT_W-1:0] digits [MaxDigits];
    logic [63:0]        rest;
    int unsigned        count;
    digit_char_t        entry;
    rest  = number & ValueMask;
    count = 0;
    // at least one digit; digits beyond the store are dropped from the top
    do begin
      digits[count] = DIGIT_W'(rest % 64'd10);
      count++;
      rest = rest / 64'd10;
    end while (rest != 64'd0 && count < MaxDigits);
    for (int i = int'(count) - 1; i >= 0; i--) begin
      entry.code = ASCII_ZERO + CHAR_W'(digits[i]);
      entry.last = (i == 0);
      digit_chars_q.push_back(entry);
    end
  endfunction

  function automatic void expect_typed(input string digits);
    digit_char_t entry;
    for (int i = 0; i < digits.len(); i++) begin
      entry.code = CHAR_W'(digits[i]);
      entry.last = (i == digits.len() - 1);
      digit_chars_q.push_back(entry);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [63:0] random_value();
    int unsigned pick;
    int unsigned bits;
    int unsigned k;
    logic [63:0] full;
    logic [63:0] ten_pow;
    full = {$urandom(), $urandom()};
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      bits = $urandom_range(1, 64);
      return full >> (64 - bits);
    end
    if (pick < 6) begin
      // next to a power of ten, where the digit count changes
      k = $urandom_range(0, 19);
      ten_pow = 64'd1;
      repeat (k) ten_pow = ten_pow * 64'd10;
      return ten_pow + 64'($urandom_range(0, 2)) - 64'd1;
    end
    if (pick == 6) begin
      return 64'($urandom_range(0, 999));
    end
    return full;
  endfunction

  task automatic send_value(input logic [63:0] number, input string digits);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= number;
    do @(posedge clk); while (!in_ready);
    if (digits.len() != 0) begin
      expect_typed(digits);
    end else begin
      expect_decimal(number);
    end
    values_sent++;
  endtask

  task automatic wait_all_digits();
    in_valid <= 1'b0;
    while (digit_chars_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    value    = '0;
    steady   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < TableRows; k++) begin
      send_value(table_values[k], table_digits[k]);
    end
    wait_all_digits();

    // first stretch without idling on either side
    steady <= 1'b1;
    for (int k = 0; k < RandomValues; k++) begin
      if (k == 100) begin
        steady <= 1'b0;
      end
      if (k == 200) begin
        wait_all_digits();
      end
      send_value(random_value(), "");
    end
    in_valid <= 1'b0;

    while (digit_chars_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("checked %0d values (%0d from the table, the rest random): %0d digits in %0d runs",
             values_sent, TableRows, chars_seen, runs_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // output back-pressure
  always @(posedge clk) begin
    int unsigned pick;
    if (steady) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (pick < 94) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 30);
      end
    end
  end

  // digit transfer check
  always @(posedge clk) begin
    digit_char_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_seen++;
      if (last_of_run) begin
        runs_seen++;
      end
      if (digit_chars_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit transfer, expected none, got char %0d last %b",
                 $time, char_code, last_of_run);
      end else begin
        want = digit_chars_q.pop_front();
        if (char_code !== want.code || last_of_run !== want.last) begin
          errors++;
          $display("%0t: digit mismatch, expected char %0d last %b, got char %0d last %b",
                   $time, want.code, want.last, char_code, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycles, digit_chars_q.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// File: binary_to_decimal_ascii_unit.f
hdl/b2da_pkg.sv
hdl/b2da_front.sv
hdl/b2da_queue.sv
hdl/b2da_back.sv
hdl/binary_to_decimal_ascii_unit.sv
hdl/b2da_checker.sv
test/binary_to_decimal_ascii_unit_test.sv
